@@ src/led_frame_remap_assert.svh @@
// Assertion helpers, sampled on clk and quiet while rst_n is low.
`ifndef LED_FRAME_REMAP_ASSERT_SVH
`define LED_FRAME_REMAP_ASSERT_SVH

// Same-cycle implication.
`define LFR_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFR_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lfr_pkg.sv @@
package lfr_pkg;

  localparam int LED_SLOTS       = 64;
  localparam int FRAME_BYTES_MAX = 256;

  localparam int OP_W   = 3;
  localparam int DATA_W = 8;
  localparam int IDX_W  = 6;
  localparam int COL_W  = 8;
  localparam int SRC_W  = 2;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 8;

  localparam int SLOT_IW = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
  localparam int CNT_W   = $clog2(FRAME_BYTES_MAX + 1);
  localparam int TRI_W   = $clog2(FRAME_BYTES_MAX / 3 + 1);

  localparam logic [SLOT_IW-1:0] SLOT_LAST = SLOT_IW'(LED_SLOTS - 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [DATA_W-1:0] MAP_OFF = 8'hFF;
  localparam logic [DATA_W-1:0] MAP_ON  = 8'hFE;

  localparam logic [7:0]       LED_COUNT_RST = 8'd64;
  localparam logic [SRC_W-1:0] RED_SRC_RST   = 2'd1;
  localparam logic [SRC_W-1:0] GREEN_SRC_RST = 2'd0;
  localparam logic [SRC_W-1:0] BLUE_SRC_RST  = 2'd2;

  localparam logic [SRC_W-1:0] PHASE_LAST = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE   = 3'd0,
    OP_RENDER = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_TWRITE = 3'd3,
    OP_IDENT  = 3'd4,
    OP_BLANK  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CMD_BYTE,
    CMD_RENDER,
    CMD_CLEAR,
    CMD_TWRITE,
    CMD_IDENT,
    CMD_BLANK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_LED_COUNT = 2'd0,
    CFG_RED_SRC   = 2'd1,
    CFG_GREEN_SRC = 2'd2,
    CFG_BLUE_SRC  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAP,
    BK_TRI,
    BK_EMIT
  } bk_state_t;

endpackage

@@ src/lfr_if.sv @@
interface lfr_in_if import lfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] data_byte;
  logic [IDX_W-1:0]  table_index;

  modport source (output valid, operation, data_byte, table_index, input ready);
  modport sink   (input valid, operation, data_byte, table_index, output ready);
endinterface

interface lfr_out_if import lfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] led_index;
  logic [COL_W-1:0] red;
  logic [COL_W-1:0] green;
  logic [COL_W-1:0] blue;
  logic             last;

  modport source (output valid, led_index, red, green, blue, last, input ready);
  modport sink   (input valid, led_index, red, green, blue, last, output ready);
endinterface

@@ src/lfr_front.sv @@
module lfr_front import lfr_pkg::*; (
  lfr_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      q_push,
  output cmd_t      q_cmd
);

  logic keep;
  logic idx_ok;
  logic val_ok;

  assign in_ch.ready = !q_full;

  assign idx_ok = {1'b0, in_ch.table_index} < (IDX_W + 1)'(LED_SLOTS);
  assign val_ok = (in_ch.data_byte < DATA_W'(LED_SLOTS)) || (in_ch.data_byte == MAP_ON);

  always_comb begin
    keep       = 1'b1;
    q_cmd.kind = CMD_BYTE;
    q_cmd.data = in_ch.data_byte;
    q_cmd.idx  = in_ch.table_index;
    unique case (in_ch.operation)
      OP_BYTE:   q_cmd.kind = CMD_BYTE;
      OP_RENDER: q_cmd.kind = CMD_RENDER;
      OP_CLEAR:  q_cmd.kind = CMD_CLEAR;
      OP_TWRITE: begin
        q_cmd.kind = CMD_TWRITE;
        // out-of-range slot: dropped here; bad value turns into OFF
        keep       = idx_ok;
        q_cmd.data = val_ok ? in_ch.data_byte : MAP_OFF;
      end
      OP_IDENT:  q_cmd.kind = CMD_IDENT;
      OP_BLANK:  q_cmd.kind = CMD_BLANK;
      default:   keep = 1'b0;
    endcase
  end

  assign q_push = in_ch.valid && in_ch.ready && keep;

endmodule

@@ src/lfr_cmd_fifo.sv @@
module lfr_cmd_fifo import lfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output cmd_t       head,
  output fifo_stat_t stat
);

  cmd_t                 fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_r;
  logic [FIFO_AW-1:0]   rptr_r;
  logic [FIFO_AW:0]     cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = fifo_mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ src/lfr_back.sv @@
module lfr_back import lfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  cmd_t              cmd,
  input  fifo_stat_t        q_stat,
  output logic              pop,
  output logic              busy,
  lfr_out_if.source         out_ch
);

  bk_state_t state_r, state_nxt;

  // config
  logic [7:0]       led_count_r;
  logic [SRC_W-1:0] red_src_r, green_src_r, blue_src_r;

  // slot map: memory plus valid bits; invalid entries read as identity or OFF
  logic [DATA_W-1:0] map_mem_r [LED_SLOTS];
  logic [LED_SLOTS-1:0] map_vld_r;
  logic              map_dflt_off_r;
  logic [DATA_W-1:0] map_q_r;
  logic              map_vld_q_r;
  logic [DATA_W-1:0] map_eff;
  logic [DATA_W-1:0] map_v_r;

  // slot colours: memory plus valid bits; invalid reads as black
  logic [3*COL_W-1:0] col_mem_r [LED_SLOTS];
  logic [LED_SLOTS-1:0] col_vld_r;
  logic [3*COL_W-1:0] col_q_r;
  logic              col_vld_q_r;

  // complete source triples, one word each
  logic [3*COL_W-1:0] tri_mem_r [LED_SLOTS];
  logic [3*COL_W-1:0] tri_q_r;
  logic [DATA_W-1:0] stg0_r, stg1_r;
  logic [CNT_W-1:0]  br_r;
  logic [SRC_W-1:0]  phase_r;
  logic [TRI_W-1:0]  tcnt_r;

  logic [SLOT_IW-1:0] slot_r;

  logic out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [3*COL_W-1:0] out_col_r;
  logic out_last_r;

  logic out_free;
  logic do_byte, do_render, do_clear, do_twrite, do_ident, do_blank;
  logic rd_slot, rd_tri, emit;
  logic byte_ok, tri_wr;
  logic [3*COL_W-1:0] old_col, pick_col, new_col;

  function automatic logic [COL_W-1:0] pick_byte(input logic [3*COL_W-1:0] w,
                                                   input logic [SRC_W-1:0] src);
    logic [COL_W-1:0] b;
    unique case (src)
      2'd0:    b = w[3*COL_W-1:2*COL_W];
      2'd1:    b = w[2*COL_W-1:COL_W];
      default: b = w[COL_W-1:0];   // 3 saturates to the third byte
    endcase
    return b;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_stat.empty && cmd.kind == CMD_RENDER) state_nxt = BK_MAP;
      BK_MAP:  state_nxt = BK_TRI;
      BK_TRI:  state_nxt = BK_EMIT;
      BK_EMIT: if (out_free) state_nxt = (slot_r == SLOT_LAST) ? BK_IDLE : BK_MAP;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // controls
  always_comb begin
    pop       = 1'b0;
    do_byte   = 1'b0;
    do_render = 1'b0;
    do_clear  = 1'b0;
    do_twrite = 1'b0;
    do_ident  = 1'b0;
    do_blank  = 1'b0;
    rd_slot   = 1'b0;
    rd_tri    = 1'b0;
    emit      = 1'b0;
    busy      = 1'b1;
    unique case (state_r)
      BK_IDLE: begin
        busy = 1'b0;
        pop  = !q_stat.empty;
        if (!q_stat.empty) begin
          unique case (cmd.kind)
            CMD_BYTE:   do_byte   = 1'b1;
            CMD_RENDER: do_render = 1'b1;
            CMD_CLEAR:  do_clear  = 1'b1;
            CMD_TWRITE: do_twrite = 1'b1;
            CMD_IDENT:  do_ident  = 1'b1;
            CMD_BLANK:  do_blank  = 1'b1;
            default:    ;
          endcase
        end
      end
      BK_MAP:  rd_slot = 1'b1;
      BK_TRI:  rd_tri  = 1'b1;
      BK_EMIT: emit    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config registers; identity op also restores the byte order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= LED_COUNT_RST;
      red_src_r   <= RED_SRC_RST;
      green_src_r <= GREEN_SRC_RST;
      blue_src_r  <= BLUE_SRC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LED_COUNT: led_count_r <= cfg_wdata;
        CFG_RED_SRC:   red_src_r   <= cfg_wdata[SRC_W-1:0];
        CFG_GREEN_SRC: green_src_r <= cfg_wdata[SRC_W-1:0];
        CFG_BLUE_SRC:  blue_src_r  <= cfg_wdata[SRC_W-1:0];
        default:       ;
      endcase
    end else if (do_ident) begin
      red_src_r   <= RED_SRC_RST;
      green_src_r <= GREEN_SRC_RST;
      blue_src_r  <= BLUE_SRC_RST;
    end
  end

  // slot map
  always_ff @(posedge clk) begin
    if (do_twrite) begin
      map_mem_r[cmd.idx[SLOT_IW-1:0]] <= cmd.data;
    end
    if (rd_slot) begin
      map_q_r     <= map_mem_r[slot_r];
      map_vld_q_r <= map_vld_r[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r      <= '0;
      map_dflt_off_r <= 1'b0;
    end else if (do_clear || do_ident) begin
      map_vld_r      <= '0;
      map_dflt_off_r <= do_clear;
    end else if (do_twrite) begin
      map_vld_r[cmd.idx[SLOT_IW-1:0]] <= 1'b1;
    end
  end

  assign map_eff = map_vld_q_r ? map_q_r : (map_dflt_off_r ? MAP_OFF : DATA_W'(slot_r));

  // frame bytes are packed into triples as they arrive
  assign byte_ok = br_r < CNT_W'(FRAME_BYTES_MAX);
  assign tri_wr  = do_byte && byte_ok && (phase_r == PHASE_LAST)
                && ({1'b0, tcnt_r} < (TRI_W + 1)'(LED_SLOTS));

  always_ff @(posedge clk) begin
    if (tri_wr) begin
      tri_mem_r[tcnt_r[SLOT_IW-1:0]] <= {stg0_r, stg1_r, cmd.data};
    end
    if (rd_tri) begin
      tri_q_r <= tri_mem_r[map_eff[SLOT_IW-1:0]];
    end
    if (do_byte && phase_r == 2'd0) begin
      stg0_r <= cmd.data;
    end
    if (do_byte && phase_r == 2'd1) begin
      stg1_r <= cmd.data;
    end
    if (rd_tri) begin
      map_v_r <= map_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_r    <= '0;
      phase_r <= '0;
      tcnt_r  <= '0;
    end else if (emit && slot_r == SLOT_LAST) begin
      br_r    <= '0;
      phase_r <= '0;
      tcnt_r  <= '0;
    end else if (do_byte && byte_ok) begin
      br_r <= br_r + 1'b1;
      if (phase_r == PHASE_LAST) begin
        phase_r <= '0;
        tcnt_r  <= tcnt_r + 1'b1;
      end else begin
        phase_r <= phase_r + 1'b1;
      end
    end
  end

  // colour for the current slot
  assign old_col  = col_vld_q_r ? col_q_r : '0;
  assign pick_col = {pick_byte(tri_q_r, red_src_r), pick_byte(tri_q_r, green_src_r),
                     pick_byte(tri_q_r, blue_src_r)};

  always_comb begin
    new_col = old_col;
    if (8'(slot_r) < led_count_r) begin
      priority if (map_v_r == MAP_OFF) begin
        new_col = '0;
      end else if (map_v_r == MAP_ON) begin
        new_col = '1;
      end else if ((TRI_W + DATA_W)'(map_v_r) < (TRI_W + DATA_W)'(tcnt_r)) begin
        new_col = pick_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      col_mem_r[slot_r] <= new_col;
    end
    if (rd_slot) begin
      col_q_r     <= col_mem_r[slot_r];
      col_vld_q_r <= col_vld_r[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_vld_r <= '0;
    end else if (do_blank) begin
      col_vld_r <= '0;
    end else if (emit) begin
      col_vld_r[slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (do_render) begin
      slot_r <= '0;
    end else if (emit) begin
      slot_r <= slot_r + 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= IDX_W'(slot_r);
      out_col_r  <= new_col;
      out_last_r <= (slot_r == SLOT_LAST);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.led_index = out_idx_r;
  assign out_ch.red       = out_col_r[3*COL_W-1:2*COL_W];
  assign out_ch.green     = out_col_r[2*COL_W-1:COL_W];
  assign out_ch.blue      = out_col_r[COL_W-1:0];
  assign out_ch.last      = out_last_r;

endmodule

@@ src/led_frame_remap.sv @@
// LED strip frame remapper.
// in_ch carries one word per operation: payload byte, render, clear table,
// table write, identity map or blank. A word is taken when valid and ready
// are high; ready drops only while the 4-deep command queue is full.
// out_ch carries one word per strip slot, 64 per render, last on slot 63.
// Non-render words are carried out once they reach the head of the queue.
// A render walks each slot through a slot map read, a triple read, and a colour
// write and output load, and finishes each slot before the next one starts.
// Words behind a render wait in the queue, and input stalls once it fills.
// If out_ch.ready is low the slot walk holds at the output register.
// cfg_we/cfg_index/cfg_wdata write led_count and the three byte selects.
// Reset: led_count 64, byte selects 1/0/2, identity slot map, all slots
// black, frame empty. Reset takes effect at once, no clearing pass.
`include "led_frame_remap_assert.svh"

module led_frame_remap import lfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  lfr_in_if.sink            in_ch,
  lfr_out_if.source         out_ch
);

  logic       fifo_push;
  cmd_t       push_cmd;
  logic       fifo_pop;
  cmd_t       fifo_head;
  fifo_stat_t fq_stat;
  logic       bk_busy;
  logic       render_pop;
  logic       last_word;

  lfr_front u_front (
    .in_ch  (in_ch),
    .q_full (fq_stat.full),
    .q_push (fifo_push),
    .q_cmd  (push_cmd)
  );

  lfr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .pop      (fifo_pop),
    .head     (fifo_head),
    .stat     (fq_stat)
  );

  lfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (fifo_head),
    .q_stat    (fq_stat),
    .pop       (fifo_pop),
    .busy      (bk_busy),
    .out_ch    (out_ch)
  );

  assign render_pop = fifo_pop && (fifo_head.kind == CMD_RENDER);
  assign last_word  = out_ch.valid && out_ch.last;

  `LFR_AST_IMP(a_no_pop_empty, fifo_pop, !fq_stat.empty, "pop from empty queue")
  `LFR_AST_IMP(a_no_pop_busy, bk_busy, !fifo_pop, "queue popped during render")
  `LFR_AST_NXT(a_render_busy, render_pop, bk_busy, "render not started")
  `LFR_AST_IMP(a_last_slot, last_word, out_ch.led_index == SLOT_LAST, "last on wrong slot")

endmodule
